>>> hdl/cil_pkg.sv
package cil_pkg;

  // Quarter turn applied to the offset, picked by the corner index
  typedef enum logic [1:0] {
    CIL_TURN_0   = 2'd0,
    CIL_TURN_90  = 2'd1,
    CIL_TURN_180 = 2'd2,
    CIL_TURN_270 = 2'd3
  } cil_turn_e;

  // Per-cell control: advance enable and incoming valid
  typedef struct packed {
    logic adv;
    logic vld;
  } cil_step_t;

endpackage

>>> hdl/cil_sqrt_cell.sv
// One bit of a restoring integer square root; radicand shifts out two bits a cell
module cil_sqrt_cell #(
  parameter int QW = 41,
  parameter int PW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cil_pkg::cil_step_t   step_i,
  input  logic [2*QW-1:0]      rad_i,
  input  logic [QW+1:0]        rem_i,
  input  logic [QW-1:0]        root_i,
  input  logic [PW-1:0]        pay_i,
  output logic                 vld_o,
  output logic [2*QW-1:0]      rad_o,
  output logic [QW+1:0]        rem_o,
  output logic [QW-1:0]        root_o,
  output logic [PW-1:0]        pay_o
);

  logic [QW+3:0] cur, trial, diff;
  logic          ge;
  logic          vld_q;
  logic [2*QW-1:0] rad_q;
  logic [QW+1:0]   rem_q;
  logic [QW-1:0]   root_q;
  logic [PW-1:0]   pay_q;

  // trial subtract of (root*4 + 1)
  always_comb begin
    cur   = {rem_i, rad_i[2*QW-1 -: 2]};
    trial = {2'b00, root_i, 2'b01};
    diff  = cur - trial;
    ge    = (cur >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (step_i.adv) begin
      vld_q <= step_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.adv) begin
      rad_q  <= {rad_i[2*QW-3:0], 2'b00};
      rem_q  <= ge ? diff[QW+1:0] : cur[QW+1:0];
      root_q <= {root_i[QW-2:0], ge};
      pay_q  <= pay_i;
    end
  end

  assign vld_o  = vld_q;
  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign pay_o  = pay_q;

endmodule

>>> hdl/cil_div_cell.sv
// One quotient bit of a restoring divide, two lanes sharing the divisor
module cil_div_cell #(
  parameter int QW = 41,
  parameter int DW = 17,
  parameter int PW = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cil_pkg::cil_step_t     step_i,
  input  logic [DW-1:0]          dv_i,
  input  logic [1:0][QW-1:0]     num_i,
  input  logic [1:0][DW-1:0]     rem_i,
  input  logic [PW-1:0]          pay_i,
  output logic                   vld_o,
  output logic [DW-1:0]          dv_o,
  output logic [1:0][QW-1:0]     num_o,
  output logic [1:0][DW-1:0]     rem_o,
  output logic [PW-1:0]          pay_o
);

  logic [1:0][DW:0]   cur, diff;
  logic [1:0]         ge;
  logic               vld_q;
  logic [DW-1:0]      dv_q;
  logic [1:0][QW-1:0] num_q;
  logic [1:0][DW-1:0] rem_q;
  logic [PW-1:0]      pay_q;

  // numerator shifts out at the top, quotient bits shift in at the bottom
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      cur[l]  = {rem_i[l], num_i[l][QW-1]};
      diff[l] = cur[l] - {1'b0, dv_i};
      ge[l]   = (cur[l] >= {1'b0, dv_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (step_i.adv) begin
      vld_q <= step_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.adv) begin
      dv_q  <= dv_i;
      pay_q <= pay_i;
      for (int l = 0; l < 2; l++) begin
        num_q[l] <= {num_i[l][QW-2:0], ge[l]};
        rem_q[l] <= ge[l] ? diff[l][DW-1:0] : cur[l][DW-1:0];
      end
    end
  end

  assign vld_o = vld_q;
  assign dv_o  = dv_q;
  assign num_o = num_q;
  assign rem_o = rem_q;
  assign pay_o = pay_q;

endmodule

>>> hdl/circle_intersection_locator.sv
// Pipeline: 4 front stages, one square-root cell and one divide cell per
//   result bit, and the output register.
// Throughput: one beat per cycle; a one-entry skid slot behind the output
//   register takes one more beat while a result waits, and the input stalls
//   only while that slot is full.
// Reset clears only the valid bits of the cells, stages and output slots.
module circle_intersection_locator #(
  parameter int DIST_BITS = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  // tdata: corner, range_near, range_next, corner_spacing, origin_x, origin_z
  input  logic [((2+3*DIST_BITS+2*(DIST_BITS+FRAC_BITS)+7)/8)*8-1:0] s_tdata_i,
  input  logic s_tvalid_i,
  output logic s_tready_o,
  // tdata: base_x, base_z, meet_x, meet_z, end_x, end_z, no_solution
  output logic [((2*(DIST_BITS+FRAC_BITS)+4*(DIST_BITS+FRAC_BITS+1)+1+7)/8)*8-1:0] m_tdata_o,
  output logic m_tvalid_o,
  input  logic m_tready_i
);

  localparam int D    = DIST_BITS;
  localparam int F    = FRAC_BITS;
  localparam int CW   = D + F;
  localparam int PB   = CW + 1;
  localparam int QW   = 2*D + 1 + F;
  localparam int RW   = 2*QW;
  localparam int XW   = 4*D + 2;
  localparam int DW   = D + 1;
  localparam int EW   = PB + 3;
  localparam int RESW = 2*CW + 4*PB + 1;
  localparam int OW   = ((RESW + 7) / 8) * 8;

  typedef struct packed {
    logic [1:0]           corner;
    logic [D-1:0]         d;
    logic [CW-1:0]        ox;
    logic [CW-1:0]        oz;
    logic                 flg;
    logic                 neg;
  } side_t;

  localparam int SW  = $bits(side_t);
  localparam int SPW = SW + QW;

  logic en;

  // ---------------- front stages ----------------
  logic [D-1:0] in_r_big, in_r_small;
  side_t        in_side;

  always_comb begin
    in_r_big        = s_tdata_i[2 +: D];
    in_r_small      = s_tdata_i[2+D +: D];
    in_side.corner  = s_tdata_i[1:0];
    in_side.d       = s_tdata_i[2+2*D +: D];
    in_side.ox      = s_tdata_i[2+3*D +: CW];
    in_side.oz      = s_tdata_i[2+3*D+CW +: CW];
    in_side.flg     = (s_tdata_i[2+2*D +: D] == '0);
    in_side.neg     = 1'b0;
  end

  logic            v1_q, v2_q, v3_q, v4_q;
  logic [2*D-1:0]  dd1_q, bb1_q, ss1_q, dd2_q, bb2_q;
  side_t           side1_q, side2_q, side3_q, side4_q;
  side_t           side2_d, side4_d;
  logic [2*D:0]    mag2_q, sum1, rr_ext;
  logic [XW-1:0]   a4_3_q, b2_3_q, xdiff;
  logic [QW-1:0]   numa3_q, numa4_q;
  logic [RW-1:0]   rad4_q;
  logic [2*D:0]    mag_d;
  logic            neg_d, xneg;
  logic [2*D-1:0]  dd_p, bb_p, ss_p;
  logic [4*D-1:0]  a_prod;
  logic [XW-1:0]   b_prod;

  always_comb begin
    dd_p   = in_side.d * in_side.d;
    bb_p   = in_r_big * in_r_big;
    ss_p   = in_r_small * in_r_small;
    sum1   = {1'b0, dd1_q} + {1'b0, bb1_q};
    rr_ext = {1'b0, ss1_q};
    neg_d  = (sum1 < rr_ext);
    mag_d  = neg_d ? (rr_ext - sum1) : (sum1 - rr_ext);
    a_prod = dd2_q * bb2_q;
    b_prod = mag2_q * mag2_q;
    xneg   = (b2_3_q > a4_3_q);
    xdiff  = a4_3_q - b2_3_q;
    side2_d         = side1_q;
    side2_d.neg     = neg_d;
    side4_d         = side3_q;
    side4_d.flg     = side3_q.flg | xneg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // squares, then |d^2+R^2-r^2|, then 4d^2R^2 and that magnitude squared, then radicand
  always_ff @(posedge clk_i) begin
    if (en) begin
      dd1_q   <= dd_p;
      bb1_q   <= bb_p;
      ss1_q   <= ss_p;
      side1_q <= in_side;
      mag2_q  <= mag_d;
      dd2_q   <= dd1_q;
      bb2_q   <= bb1_q;
      side2_q <= side2_d;
      a4_3_q  <= {a_prod, 2'b00};
      b2_3_q  <= b_prod;
      numa3_q <= {mag2_q, {F{1'b0}}};
      side3_q <= side2_q;
      rad4_q  <= xneg ? '0 : {xdiff, {(2*F){1'b0}}};
      numa4_q <= numa3_q;
      side4_q <= side4_d;
    end
  end

  // ---------------- square-root chain ----------------
  logic [QW:0]           sq_vld;
  logic [QW:0][RW-1:0]   sq_rad;
  logic [QW:0][QW+1:0]   sq_rem;
  logic [QW:0][QW-1:0]   sq_root;
  logic [QW:0][SPW-1:0]  sq_pay;

  assign sq_vld[0]  = v4_q;
  assign sq_rad[0]  = rad4_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_pay[0]  = {side4_q, numa4_q};

  for (genvar i = 0; i < QW; i++) begin : g_sqrt
    cil_sqrt_cell #(.QW(QW), .PW(SPW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (cil_pkg::cil_step_t'{adv: en, vld: sq_vld[i]}),
      .rad_i  (sq_rad[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .pay_i  (sq_pay[i]),
      .vld_o  (sq_vld[i+1]),
      .rad_o  (sq_rad[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .pay_o  (sq_pay[i+1])
    );
  end

  // ---------------- divide chain: along and height over 2d ----------------
  side_t sq_side;
  assign sq_side = sq_pay[QW][SPW-1 -: SW];

  logic [QW:0]                 dv_vld;
  logic [QW:0][DW-1:0]         dv_div;
  logic [QW:0][1:0][QW-1:0]    dv_num;
  logic [QW:0][1:0][DW-1:0]    dv_rem;
  logic [QW:0][SW-1:0]         dv_pay;

  assign dv_vld[0]    = sq_vld[QW];
  assign dv_div[0]    = {sq_side.d, 1'b0};
  assign dv_num[0][0] = sq_pay[QW][QW-1:0];
  assign dv_num[0][1] = sq_root[QW];
  assign dv_rem[0]    = '0;
  assign dv_pay[0]    = sq_side;

  for (genvar i = 0; i < QW; i++) begin : g_div
    cil_div_cell #(.QW(QW), .DW(DW), .PW(SW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (cil_pkg::cil_step_t'{adv: en, vld: dv_vld[i]}),
      .dv_i   (dv_div[i]),
      .num_i  (dv_num[i]),
      .rem_i  (dv_rem[i]),
      .pay_i  (dv_pay[i]),
      .vld_o  (dv_vld[i+1]),
      .dv_o   (dv_div[i+1]),
      .num_o  (dv_num[i+1]),
      .rem_o  (dv_rem[i+1]),
      .pay_o  (dv_pay[i+1])
    );
  end

  // ---------------- cap, rotate, place, saturate ----------------
  function automatic logic [PB:0] sat_pt(input logic [EW-1:0] v);
    logic ovf;
    ovf = !((v[EW-1:PB-1] == '0) || (v[EW-1:PB-1] == '1));
    if (!ovf) begin
      sat_pt = {1'b0, v[PB-1:0]};
    end else if (v[EW-1]) begin
      sat_pt = {1'b1, 1'b1, {(PB-1){1'b0}}};
    end else begin
      sat_pt = {1'b1, 1'b0, {(PB-1){1'b1}}};
    end
  endfunction

  side_t           rs;
  logic [QW-1:0]   qa, qh;
  logic            d0, ovfa, ovfh, res_flag;
  logic [PB:0]     am, hm;
  logic [EW-1:0]   along_e, height_e, ox_e, oz_e, dq_e, mx, mz, ex, ez;
  logic [PB:0]     smx, smz, sex, sez;
  logic [RESW-1:0] res;

  always_comb begin
    rs       = dv_pay[QW];
    qa       = dv_num[QW][0];
    qh       = dv_num[QW][1];
    d0       = (rs.d == '0);
    ovfa     = |qa[QW-1:PB];
    ovfh     = |qh[QW-1:PB];
    am       = d0 ? '0 : (ovfa ? {1'b1, {PB{1'b0}}} : {1'b0, qa[PB-1:0]});
    hm       = d0 ? '0 : (ovfh ? {1'b1, {PB{1'b0}}} : {1'b0, qh[PB-1:0]});
    along_e  = rs.neg ? -EW'(am) : EW'(am);
    height_e = EW'(hm);
    ox_e     = {{(EW-CW){rs.ox[CW-1]}}, rs.ox};
    oz_e     = {{(EW-CW){rs.oz[CW-1]}}, rs.oz};
    dq_e     = EW'({rs.d, {F{1'b0}}});
    case (cil_pkg::cil_turn_e'(rs.corner))
      cil_pkg::CIL_TURN_0: begin
        mx = ox_e + along_e;  mz = oz_e + height_e; ex = ox_e + dq_e; ez = oz_e;
      end
      cil_pkg::CIL_TURN_90: begin
        mx = ox_e + height_e; mz = oz_e - along_e;  ex = ox_e; ez = oz_e - dq_e;
      end
      cil_pkg::CIL_TURN_180: begin
        mx = ox_e - along_e;  mz = oz_e - height_e; ex = ox_e - dq_e; ez = oz_e;
      end
      default: begin
        mx = ox_e - height_e; mz = oz_e + along_e;  ex = ox_e; ez = oz_e + dq_e;
      end
    endcase
    smx      = sat_pt(mx);
    smz      = sat_pt(mz);
    sex      = sat_pt(ex);
    sez      = sat_pt(ez);
    res_flag = rs.flg | (!d0 & (ovfa | ovfh)) | smx[PB] | smz[PB] | sex[PB] | sez[PB];
    res      = {res_flag, sez[PB-1:0], sex[PB-1:0], smz[PB-1:0], smx[PB-1:0],
                rs.oz, rs.ox};
  end

  // ---------------- output register with skid slot ----------------
  logic            out_vld_q, skid_full_q;
  logic [RESW-1:0] out_q, skid_q;
  logic            res_vld;

  assign res_vld = dv_vld[QW];
  assign en      = !skid_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q   <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (m_tready_i) begin
        skid_full_q <= 1'b0;
      end
    end else if (!out_vld_q || m_tready_i) begin
      out_vld_q <= res_vld;
    end else if (res_vld) begin
      skid_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_full_q) begin
      if (m_tready_i) begin
        out_q <= skid_q;
      end
    end else if (!out_vld_q || m_tready_i) begin
      out_q <= res;
    end else begin
      skid_q <= res;
    end
  end

  assign s_tready_o = en;
  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = OW'(out_q);

`ifndef ASSERT_OFF
  // skid slot only holds a beat while the output register is also full
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q |-> out_vld_q)
    else $error("skid slot full with empty output register");

  // skid slot fills only when the output was stalled
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_full_q) |-> $past(out_vld_q && !m_tready_i))
    else $error("skid slot filled without output stall");

  // zero spacing always raises the flag
  a_zero_spacing_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld && d0) |-> res_flag)
    else $error("zero spacing without no_solution");

  // input is refused exactly while the skid slot is occupied
  a_stall_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_o == !skid_full_q)
    else $error("input ready does not track skid slot");
`endif

endmodule

>>> test/tb.sv
module tb;

  localparam int DB = 16;
  localparam int FB = 8;
  localparam int IN_W = ((2+3*DB+2*(DB+FB)+7)/8)*8;
  localparam int OUT_W = ((2*(DB+FB)+4*(DB+FB+1)+1+7)/8)*8;
  localparam int LATENCY = 2*(2*DB+1+FB)+5;
  localparam longint CYCLE_LIMIT = 600000;

  // Geometry model and queue of expected results
  class locator_board;
    logic [148:0] expected_q[$];
    int errors = 0;

    function automatic longint clamp_mag(logic [127:0] v, ref bit flag);
      if (v >= 128'(1 << 25)) begin
        flag = 1;
        return longint'(1) << 25;
      end
      return longint'(v[63:0]);
    endfunction

    function automatic logic [24:0] clamp_point(longint v, ref bit flag);
      longint hi;
      hi = (longint'(1) << 24) - 1;
      if (v > hi) begin
        v = hi;
        flag = 1;
      end
      if (v < -hi - 1) begin
        v = -hi - 1;
        flag = 1;
      end
      return v[24:0];
    endfunction

    function automatic logic [148:0] locate(logic [97:0] beat);
      logic [1:0] c;
      logic [127:0] d, bR, br, dd, RR, rr, s, mag, num, q, a4, b2, h, t;
      bit neg, flag;
      longint along, height, ox, oz, dq, mx, mz, ex, ez;
      logic [24:0] pmx, pmz, pex, pez;
      c = beat[1:0];
      bR = 128'(beat[17:2]);
      br = 128'(beat[33:18]);
      d = 128'(beat[49:34]);
      ox = longint'($signed(beat[73:50]));
      oz = longint'($signed(beat[97:74]));
      along = 0;
      height = 0;
      flag = 0;
      if (d == 0) begin
        flag = 1;
      end else begin
        dd = d * d;
        RR = bR * bR;
        rr = br * br;
        s = dd + RR;
        neg = s < rr;
        mag = neg ? rr - s : s - rr;
        q = (mag << FB) / (d << 1);
        along = clamp_mag(q, flag);
        if (neg) along = -along;
        a4 = (dd * RR) << 2;
        b2 = mag * mag;
        if (b2 > a4) begin
          flag = 1;
        end else begin
          q = ((a4 - b2) << (2 * FB)) / (dd << 2);
          h = 0;
          for (int i = 63; i >= 0; i--) begin
            t = h | (128'(1) << i);
            if (t * t <= q) h = t;
          end
          height = clamp_mag(h, flag);
        end
      end
      dq = longint'(d[63:0]) << FB;
      case (cil_pkg::cil_turn_e'(c))
        cil_pkg::CIL_TURN_0: begin
          mx = ox + along; mz = oz + height; ex = ox + dq; ez = oz;
        end
        cil_pkg::CIL_TURN_90: begin
          mx = ox + height; mz = oz - along; ex = ox; ez = oz - dq;
        end
        cil_pkg::CIL_TURN_180: begin
          mx = ox - along; mz = oz - height; ex = ox - dq; ez = oz;
        end
        default: begin
          mx = ox - height; mz = oz + along; ex = ox; ez = oz + dq;
        end
      endcase
      pmx = clamp_point(mx, flag);
      pmz = clamp_point(mz, flag);
      pex = clamp_point(ex, flag);
      pez = clamp_point(ez, flag);
      return {flag, pez, pex, pmz, pmx, beat[97:74], beat[73:50]};
    endfunction

    function void note_input(logic [97:0] beat);
      expected_q.push_back(locate(beat));
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [148:0] got);
      logic [148:0] want;
      string names[7];
      int lo[7], wd[7];
      logic [148:0] fw, fg;
      names = '{"base_x", "base_z", "meet_x", "meet_z", "end_x", "end_z", "no_solution"};
      lo = '{0, 24, 48, 73, 98, 123, 148};
      wd = '{24, 24, 25, 25, 25, 25, 1};
      if (expected_q.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      for (int i = 0; i < 7; i++) begin
        fw = (want >> lo[i]) & ((149'(1) << wd[i]) - 1);
        fg = (got >> lo[i]) & ((149'(1) << wd[i]) - 1);
        if (fw !== fg) report($sformatf("%s got %h want %h", names[i], fg, fw));
      end
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic [IN_W-1:0] s_tdata = '0;
  logic s_tvalid = 0;
  logic s_tready_o;
  logic [OUT_W-1:0] m_tdata_o;
  logic m_tvalid_o;
  logic m_tready = 0;

  locator_board board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  bit hold_taken = 0;
  int hold_cycles = 0;
  longint cycle_count = 0;

  circle_intersection_locator DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_tdata_i(s_tdata),
    .s_tvalid_i(s_tvalid),
    .s_tready_o(s_tready_o),
    .m_tdata_o(m_tdata_o),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: random stalls plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cycles <= 400;
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Beat monitors on both sides
  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_tready_o) board.note_input(s_tdata[97:0]);
    if (rst_ni && m_tvalid_o && m_tready) board.check_result(m_tdata_o[148:0]);
  end

  // Run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL circle_intersection_locator");
      $finish;
    end
  end

  function automatic logic [97:0] pack_beat(int c, int bR, int br, int d, int ox, int oz);
    return {oz[23:0], ox[23:0], d[15:0], br[15:0], bR[15:0], c[1:0]};
  endfunction

  function automatic int pick_origin();
    case ($urandom_range(7))
      0: return 8388607;
      1: return -8388608;
      2: return $urandom_range(2000) - 1000;
      default: return $signed($urandom_range(24'hffffff) << 8) >>> 8;
    endcase
  endfunction

  // Mostly geometrically valid triangles, the rest arbitrary
  function automatic logic [97:0] random_beat();
    int d, bR, br, lo, hi, span;
    span = ($urandom_range(3) == 0) ? 300 : 65535;
    d = $urandom_range(span);
    bR = $urandom_range(span);
    if ($urandom_range(9) < 7) begin
      lo = (d > bR) ? d - bR : bR - d;
      hi = (d + bR > 65535) ? 65535 : d + bR;
      br = $urandom_range(hi, lo);
    end else begin
      br = $urandom_range(span);
    end
    return pack_beat($urandom_range(3), bR, br, d, pick_origin(), pick_origin());
  endfunction

  task send_beat(logic [97:0] beat);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_W'(beat);
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
  endtask

  task drain();
    s_tvalid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int idle_set[4], stall_set[4];
    idle_set = '{0, 54, 0, 30};
    stall_set = '{0, 0, 54, 30};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corner cases over all four quarter turns
    for (int c = 0; c < 4; c++) begin
      send_beat(pack_beat(c, 5, 5, 6, 0, 0));
      send_beat(pack_beat(c, 3, 4, 7, 256, -256));
      send_beat(pack_beat(c, 1, 1, 0, 100, 100));
      send_beat(pack_beat(c, 65535, 65535, 65535, 8388607, -8388608));
    end
    send_beat(pack_beat(0, 1, 1, 10, 0, 0));
    send_beat(pack_beat(1, 100, 2, 10, 0, 0));
    send_beat(pack_beat(2, 0, 0, 65535, -8388608, -8388608));
    send_beat(pack_beat(3, 65535, 0, 1, 0, 0));
    send_beat(pack_beat(0, 0, 65535, 1, -1, -1));
    send_beat(pack_beat(1, 4, 3, 5, 8388607, 8388607));
    drain();

    // Random phases with different idling; a long receiver hold-off first
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_set[ph];
      recv_stall_pct = stall_set[ph];
      if (ph == 0) hold_req = 1'b1;
      for (int n = 0; n < 410; n++) send_beat(random_beat());
      drain();
    end

    repeat (LATENCY + 20) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("PASS circle_intersection_locator");
    end else begin
      $display("FAIL circle_intersection_locator");
    end
    $finish;
  end
endmodule
